// ===== rtl/source_tokenizer_top_defines.svh =====
// Assertion macros used by the tokenizer's token queue.
// Each one samples on clk and is disabled while rst_n is low.
`ifndef SOURCE_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TOKENIZER_TOP_DEFINES_SVH

// The condition implies the consequence in the same cycle.
`define STOK_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("stok: same-cycle check failed");

// The condition implies the consequence in the next cycle.
`define STOK_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("stok: next-cycle check failed");

`endif

// ===== rtl/stok_pkg.sv =====
package stok_pkg;

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_SLASH,
        M_OP2,
        M_LINE,
        M_BLOCK,
        M_BSTAR
    } mode_t;

    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACE   = 6'd2;
    localparam logic [5:0] K_RBRACE   = 6'd3;
    localparam logic [5:0] K_SEMI     = 6'd4;
    localparam logic [5:0] K_COMMA    = 6'd5;
    localparam logic [5:0] K_DOT      = 6'd6;
    localparam logic [5:0] K_MINUS    = 6'd7;
    localparam logic [5:0] K_PLUS     = 6'd8;
    localparam logic [5:0] K_SLASH    = 6'd9;
    localparam logic [5:0] K_STAR     = 6'd10;
    localparam logic [5:0] K_BANG     = 6'd11;
    localparam logic [5:0] K_EQUAL    = 6'd13;
    localparam logic [5:0] K_LESS     = 6'd15;
    localparam logic [5:0] K_GREATER  = 6'd17;
    localparam logic [5:0] K_STRING   = 6'd19;
    localparam logic [5:0] K_NUMBER   = 6'd20;
    localparam logic [5:0] K_IDENT    = 6'd21;
    localparam logic [5:0] K_EOF      = 6'd37;
    localparam logic [5:0] K_ERROR    = 6'd38;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_UNTERM   = 2'd1;
    localparam logic [1:0] E_UNEXP    = 2'd2;

    localparam logic [23:0] LINE_LIMIT = 24'hFFFFFF;
    localparam logic [15:0] LEN_LIMIT  = 16'hFFFF;

    // Keyword spellings, right-justified: last character in the low byte.
    localparam logic [63:0] KW_TEXT [16] = '{
        64'("break"), 64'("else"), 64'("null"), 64'("return"), 64'("while"),
        64'("class"), 64'("continue"), 64'("switch"), 64'("super"),
        64'("false"), 64'("for"), 64'("fun"), 64'("this"), 64'("true"),
        64'("if"), 64'("i32")
    };
    localparam logic [3:0] KW_LEN [16] = '{
        4'd5, 4'd4, 4'd4, 4'd6, 4'd5, 4'd5, 4'd8, 4'd6,
        4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd4, 4'd2, 4'd3
    };
    localparam logic [5:0] KW_KIND [16] = '{
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, K_NUMBER
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err_code;
        logic [23:0] start_offset;
        logic [15:0] token_length;
        logic [23:0] line_number;
    } tok_t;

    // Tokens caused by one input byte; tok[0] goes out first.
    typedef struct packed {
        tok_t [1:0] tok;
        logic [1:0] cnt;
    } rec_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] single_kind(logic [7:0] c);
        logic [5:0] k;
        case (c)
            "!":     k = K_BANG;
            "=":     k = K_EQUAL;
            "<":     k = K_LESS;
            default: k = K_GREATER;
        endcase
        return k;
    endfunction

    // len is 0 when the word is too long to be a keyword.
    function automatic logic [5:0] word_kind(logic [7:0][7:0] pfx, logic [3:0] len);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int w = 0; w < 16; w++) begin
            hit = (len == KW_LEN[w]);
            for (int i = 0; i < 8; i++) begin
                if (i < int'(KW_LEN[w])) begin
                    hit = hit && (pfx[i] == KW_TEXT[w][8*(int'(KW_LEN[w])-1-i) +: 8]);
                end
            end
            if (hit) begin
                k = KW_KIND[w];
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/stok_if.sv =====
interface stok_in_if;
    import stok_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_source;

    modport source (output valid, output ch, output end_of_source, input ready);
    modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

interface stok_out_if;
    import stok_pkg::*;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic [1:0]  err_code;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic        last;

    modport source (output valid, output kind, output err_code, output start_offset,
                    output token_length, output line_number, output last, input ready);
    modport sink   (input valid, input kind, input err_code, input start_offset,
                    input token_length, input line_number, input last, output ready);
endinterface

// ===== rtl/stok_front.sv =====
module stok_front
    import stok_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int KEYWORD_MAX = 8
)(
    input  logic        clk,
    input  logic        rst_n,
    stok_in_if.sink     src,
    input  logic        full,
    output logic        push,
    output rec_t        rec
);

    localparam int IW = $clog2(KEYWORD_MAX);
    localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;

    mode_t                  mode_reg,  mode_next;
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [23:0]            line_reg,  line_next;
    logic [15:0]            len_reg,   len_next;
    logic [7:0]             pend_reg,  pend_next;
    logic [7:0]             pfx_reg [KEYWORD_MAX];

    logic          pfx_we;
    logic [IW-1:0] pfx_idx;
    logic [7:0]    c;
    logic          accept, rescan, a_v, b_v, p_v, p_err;
    tok_t          a_tok, b_tok;
    logic [5:0]    p_kind, wkind;
    logic [23:0]   line_inc;
    logic [15:0]   len_inc;
    logic [7:0][7:0] pfx8;

    function automatic tok_t mk(logic [5:0] k, logic [1:0] e,
                                logic [OFFSET_BITS-1:0] s, logic [15:0] l,
                                logic [23:0] ln);
        tok_t t;
        t.kind         = k;
        t.err_code     = e;
        t.start_offset = 24'(s);
        t.token_length = l;
        t.line_number  = ln;
        return t;
    endfunction

    assign c       = src.ch;
    assign src.ready = !full;
    assign accept  = src.valid && !full;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            pfx8[i] = pfx_reg[i];
        end
    end

    assign wkind    = word_kind(pfx8, (len_reg <= 16'd8) ? len_reg[3:0] : 4'd0);
    assign line_inc = (line_reg == LINE_LIMIT) ? line_reg : line_reg + 24'd1;
    assign len_inc  = (len_reg == LEN_LIMIT) ? len_reg : len_reg + 16'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        line_next  = line_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        pfx_we     = 1'b0;
        pfx_idx    = '0;
        a_v = 1'b0; a_tok = '0;
        b_v = 1'b0; b_tok = '0;
        rescan = 1'b0;
        p_v = 1'b0; p_err = 1'b0; p_kind = K_LPAREN;
        if (src.end_of_source)
        begin
            // Flush the pending token, close with eof, return to reset.
            case (mode_reg)
                M_IDENT:  begin a_v = 1'b1; a_tok = mk(wkind, E_NONE, start_reg, len_reg, line_reg); end
                M_NUMBER: begin a_v = 1'b1; a_tok = mk(K_NUMBER, E_NONE, start_reg, len_reg, line_reg); end
                M_STRING: begin a_v = 1'b1; a_tok = mk(K_ERROR, E_UNTERM, start_reg, 16'd0, line_reg); end
                M_SLASH:  begin a_v = 1'b1; a_tok = mk(K_SLASH, E_NONE, start_reg, 16'd1, line_reg); end
                M_OP2:    begin a_v = 1'b1;
                                a_tok = mk(single_kind(pend_reg), E_NONE, start_reg, 16'd1, line_reg); end
                default:  ;
            endcase
            b_v = 1'b1;
            b_tok = mk(K_EOF, E_NONE, pos_reg, 16'd0, line_reg);
            mode_next  = M_IDLE;
            pos_next   = '0;
            start_next = '0;
            line_next  = '0;
            len_next   = '0;
            pend_next  = '0;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (len_reg < 16'(KEYWORD_MAX))
                        begin
                            pfx_we  = 1'b1;
                            pfx_idx = len_reg[IW-1:0];
                        end
                        len_next = len_inc;
                    end
                    else
                    begin
                        a_v = 1'b1; a_tok = mk(wkind, E_NONE, start_reg, len_reg, line_reg);
                        rescan = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        len_next = len_inc;
                    end
                    else
                    begin
                        a_v = 1'b1; a_tok = mk(K_NUMBER, E_NONE, start_reg, len_reg, line_reg);
                        rescan = 1'b1;
                    end
                end
                M_STRING:
                begin
                    len_next = len_inc;
                    if (c == "\n")
                    begin
                        line_next = line_inc;
                    end
                    if (c == "\"")
                    begin
                        a_v = 1'b1; a_tok = mk(K_STRING, E_NONE, start_reg, len_inc, line_reg);
                        mode_next = M_IDLE;
                    end
                end
                M_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = M_LINE;
                    end
                    else if (c == "*")
                    begin
                        mode_next = M_BLOCK;
                    end
                    else
                    begin
                        a_v = 1'b1; a_tok = mk(K_SLASH, E_NONE, start_reg, 16'd1, line_reg);
                        rescan = 1'b1;
                    end
                end
                M_OP2:
                begin
                    if (c == "=")
                    begin
                        a_v = 1'b1;
                        a_tok = mk(single_kind(pend_reg) + 6'd1, E_NONE, start_reg, 16'd2, line_reg);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_tok = mk(single_kind(pend_reg), E_NONE, start_reg, 16'd1, line_reg);
                        rescan = 1'b1;
                    end
                end
                M_LINE:
                begin
                    if (c == "\n")
                    begin
                        line_next = line_inc;
                        mode_next = M_IDLE;
                    end
                end
                M_BLOCK:
                begin
                    if (c == "\n")
                    begin
                        line_next = line_inc;
                    end
                    else if (c == "*")
                    begin
                        mode_next = M_BSTAR;
                    end
                end
                M_BSTAR:
                begin
                    if (c == "/")
                    begin
                        mode_next = M_IDLE;
                    end
                    else if (c != "*")
                    begin
                        if (c == "\n")
                        begin
                            line_next = line_inc;
                        end
                        mode_next = M_BLOCK;
                    end
                end
                default: rescan = 1'b1;
            endcase

            if (rescan)
            begin
                // Scan the byte as the first of a new token.
                mode_next  = M_IDLE;
                start_next = pos_reg;
                len_next   = 16'd1;
                if (c == " " || c == "\r" || c == "\t")
                begin
                end
                else if (c == "\n")
                begin
                    line_next = line_inc;
                end
                else if (is_alpha(c))
                begin
                    mode_next = M_IDENT;
                    pfx_we    = 1'b1;
                    pfx_idx   = '0;
                end
                else if (is_digit(c))
                begin
                    mode_next = M_NUMBER;
                end
                else
                begin
                    case (c)
                        "\"": mode_next = M_STRING;
                        "/":  mode_next = M_SLASH;
                        "!", "=", "<", ">":
                        begin
                            mode_next = M_OP2;
                            pend_next = c;
                        end
                        "(": begin p_v = 1'b1; p_kind = K_LPAREN; end
                        ")": begin p_v = 1'b1; p_kind = K_RPAREN; end
                        "{": begin p_v = 1'b1; p_kind = K_LBRACE; end
                        "}": begin p_v = 1'b1; p_kind = K_RBRACE; end
                        ";": begin p_v = 1'b1; p_kind = K_SEMI;   end
                        ",": begin p_v = 1'b1; p_kind = K_COMMA;  end
                        ".": begin p_v = 1'b1; p_kind = K_DOT;    end
                        "-": begin p_v = 1'b1; p_kind = K_MINUS;  end
                        "+": begin p_v = 1'b1; p_kind = K_PLUS;   end
                        "*": begin p_v = 1'b1; p_kind = K_STAR;   end
                        default: p_err = 1'b1;
                    endcase
                end
                if (p_v)
                begin
                    b_v = 1'b1; b_tok = mk(p_kind, E_NONE, pos_reg, 16'd1, line_reg);
                end
                else if (p_err)
                begin
                    b_v = 1'b1; b_tok = mk(K_ERROR, E_UNEXP, pos_reg, 16'd0, line_reg);
                end
            end
            pos_next = (pos_reg == POS_LIMIT) ? pos_reg : pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        rec.cnt    = {1'b0, a_v} + {1'b0, b_v};
        rec.tok[0] = a_v ? a_tok : b_tok;
        rec.tok[1] = b_tok;
    end

    assign push = accept && (a_v || b_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            line_reg  <= '0;
            len_reg   <= '0;
            pend_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            line_reg  <= line_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pfx_we)
        begin
            pfx_reg[pfx_idx] <= c;
        end
    end

endmodule

// ===== rtl/stok_fifo.sv =====
`include "source_tokenizer_top_defines.svh"

module stok_fifo
    import stok_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [PW-1:0] wrap(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? wrap(wr_reg) : wr_reg;
        rd_next    = pop ? wrap(rd_reg) : rd_reg;
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    `STOK_ASSERT_NOW(a_no_overflow, push, count_reg != CW'(DEPTH))
    `STOK_ASSERT_NOW(a_no_underflow, pop, count_reg != '0)
    `STOK_ASSERT_NEXT(a_push_fills, push && !pop, count_reg != '0)

endmodule

// ===== rtl/stok_back.sv =====
module stok_back
    import stok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rec_t        head,
    input  logic        empty,
    output logic        pop,
    stok_out_if.source  tok
);

    logic idx_reg, idx_next;
    logic fin, take;
    tok_t cur;

    assign cur  = idx_reg ? head.tok[1] : head.tok[0];
    assign fin  = idx_reg || (head.cnt == 2'd1);
    assign take = tok.valid && tok.ready;
    assign pop  = take && fin;

    assign tok.valid        = !empty;
    assign tok.kind         = cur.kind;
    assign tok.err_code     = cur.err_code;
    assign tok.start_offset = cur.start_offset;
    assign tok.token_length = cur.token_length;
    assign tok.line_number  = cur.line_number;
    assign tok.last         = fin;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = !fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== rtl/source_tokenizer_top.sv =====
// Channel | Dir | Payload                                             | Role
// src     | in  | ch, end_of_source                                   | one source byte
// tok     | out | kind, err_code, start_offset, token_length,         | one token
//         |     | line_number, last                                   |
//
// One byte is taken per cycle while src is ready; the scanner updates its mode in that cycle.
// A byte yields zero, one or two tokens; the output side sends one token per
// cycle while tok is ready, so a run of two-token bytes is bounded by the output port.
// Reset (rst_n low, asynchronous) returns the scanner to idle at offset 0,
// line 0 and empties the token queue.
// src stalls only when the four-entry token queue is full; tok stalls hold
// the queue head until taken.
module source_tokenizer_top
    import stok_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int KEYWORD_MAX = 8
)(
    input  logic       clk,
    input  logic       rst_n,
    stok_in_if.sink    src,
    stok_out_if.source tok
);

    localparam int QUEUE_DEPTH = 4;

    rec_t push_rec, head_rec;
    logic push, pop, full, empty;
    logic [$bits(rec_t)-1:0] head_bits;

    // Front: classify each byte and build the tokens it closes.
    stok_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .full  (full),
        .push  (push),
        .rec   (push_rec)
    );

    // Queue: decouple scanning from token delivery.
    stok_fifo #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_rec),
        .pop   (pop),
        .rdata (head_bits),
        .full  (full),
        .empty (empty)
    );

    assign head_rec = rec_t'(head_bits);

    // Back: send each queued token, mark the last of each byte.
    stok_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head_rec),
        .empty (empty),
        .pop   (pop),
        .tok   (tok)
    );

endmodule

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
    import stok_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes for the two-character operators sit one above their single form
    localparam logic [5:0] K_BANG_EQUAL    = K_BANG + 6'd1;
    localparam logic [5:0] K_EQUAL_EQUAL   = K_EQUAL + 6'd1;
    localparam logic [5:0] K_LESS_EQUAL    = K_LESS + 6'd1;
    localparam logic [5:0] K_GREATER_EQUAL = K_GREATER + 6'd1;
    localparam logic [23:0] OFFSET_TOP     = 24'hFFFFFF;
    localparam int          PREFIX_DEPTH   = 8;

    logic clk;
    logic rst_n;

    stok_in_if  src ();
    stok_out_if tok ();

    source_tokenizer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src.sink),
        .tok   (tok.source)
    );

    typedef struct {
        logic [5:0]  kind;
        logic [1:0]  err_code;
        logic [23:0] start_offset;
        logic [15:0] token_length;
        logic [23:0] line_number;
        logic        last;
    } token_exp_t;

    // Directed row: one byte or end marker, with the first token typed in when it is obvious
    typedef struct {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        logic [5:0] kind;
        logic [1:0] err_code;
    } lex_row_t;

    token_exp_t token_q[$];

    // Scanner shadow state
    mode_t       scan_mode;
    logic [23:0] byte_pos;
    logic [23:0] tok_start;
    logic [23:0] line_cnt;
    logic [15:0] lex_len;
    logic [7:0]  word_pfx [PREFIX_DEPTH];
    logic [7:0]  held_op;

    string keyword_text [16] = '{"break", "else", "null", "return", "while", "class",
        "continue", "switch", "super", "false", "for", "fun", "this", "true", "if", "i32"};

    int  fail_cnt;
    int  bytes_sent;
    int  sources_closed;
    int  tokens_seen;
    bit  calm;       // suppress idling on both sides while set
    bit  stim_done;

    lex_row_t lex_rows [25] = '{
        '{"a",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"(",    1'b0, 1'b1, K_IDENT,   E_NONE},
        '{"!",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"=",    1'b0, 1'b1, K_BANG_EQUAL, E_NONE},
        '{"<",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{">",    1'b0, 1'b1, K_LESS,    E_NONE},
        '{" ",    1'b0, 1'b1, K_GREATER, E_NONE},
        '{"/",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"/",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"x",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{8'h0A,  1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"/",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"*",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"*",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"/",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{8'h00,  1'b0, 1'b1, K_ERROR,   E_UNEXP},
        '{8'hFF,  1'b0, 1'b1, K_ERROR,   E_UNEXP},
        '{"i",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"3",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"2",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{";",    1'b0, 1'b1, K_NUMBER,  E_NONE},
        '{8'h22,  1'b0, 1'b0, K_IDENT,   E_NONE},
        '{"q",    1'b0, 1'b0, K_IDENT,   E_NONE},
        '{8'h00,  1'b1, 1'b1, K_ERROR,   E_UNTERM},
        '{8'h00,  1'b1, 1'b1, K_EOF,     E_NONE}
    };

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] op_single(logic [7:0] c);
        case (c)
            "!":     return K_BANG;
            "=":     return K_EQUAL;
            "<":     return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    function automatic logic [5:0] classify_word();
        bit hit;
        if (lex_len > PREFIX_DEPTH)
            return K_IDENT;
        for (int w = 0; w < 16; w++)
        begin
            hit = (keyword_text[w].len() == int'(lex_len));
            for (int i = 0; hit && i < int'(lex_len); i++)
                hit = (word_pfx[i] == keyword_text[w][i]);
            if (hit)
                return KW_KIND[w];
        end
        return K_IDENT;
    endfunction

    function automatic void push_token(logic [5:0] k, logic [1:0] e, logic [23:0] s,
                                       logic [15:0] l);
        token_exp_t t;
        t = '{k, e, s, l, line_cnt, 1'b0};
        token_q.push_back(t);
    endfunction

    function automatic void count_line();
        if (line_cnt != OFFSET_TOP)
            line_cnt++;
    endfunction

    function automatic void clear_scanner();
        scan_mode = M_IDLE;
        byte_pos  = '0;
        tok_start = '0;
        line_cnt  = '0;
        lex_len   = '0;
        held_op   = '0;
        foreach (word_pfx[i])
            word_pfx[i] = '0;
    endfunction

    // Scan one byte from the between-tokens state
    function automatic void scan_fresh(logic [7:0] c);
        logic [5:0] k;
        scan_mode = M_IDLE;
        tok_start = byte_pos;
        lex_len   = 16'd1;
        if (c == " " || c == 8'h0D || c == 8'h09)
            return;
        if (c == 8'h0A)
        begin
            count_line();
            return;
        end
        if (is_letter(c))
        begin
            scan_mode   = M_IDENT;
            word_pfx[0] = c;
            return;
        end
        if (is_num(c))
        begin
            scan_mode = M_NUMBER;
            return;
        end
        case (c)
            8'h22: begin scan_mode = M_STRING; return; end
            "/":   begin scan_mode = M_SLASH; return; end
            "!", "=", "<", ">":
            begin
                scan_mode = M_OP2;
                held_op   = c;
                return;
            end
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            "-": k = K_MINUS;
            "+": k = K_PLUS;
            "*": k = K_STAR;
            default:
            begin
                push_token(K_ERROR, E_UNEXP, byte_pos, 16'd0);
                return;
            end
        endcase
        push_token(k, E_NONE, byte_pos, 16'd1);
    endfunction

    function automatic void scan_next(logic [7:0] c);
        case (scan_mode)
            M_IDENT:
            begin
                if (is_letter(c) || is_num(c))
                begin
                    if (lex_len < PREFIX_DEPTH)
                        word_pfx[lex_len] = c;
                    if (lex_len != LEN_LIMIT)
                        lex_len++;
                    return;
                end
                push_token(classify_word(), E_NONE, tok_start, lex_len);
            end
            M_NUMBER:
            begin
                if (is_num(c))
                begin
                    if (lex_len != LEN_LIMIT)
                        lex_len++;
                    return;
                end
                push_token(K_NUMBER, E_NONE, tok_start, lex_len);
            end
            M_STRING:
            begin
                if (lex_len != LEN_LIMIT)
                    lex_len++;
                if (c == 8'h0A)
                    count_line();
                if (c == 8'h22)
                begin
                    push_token(K_STRING, E_NONE, tok_start, lex_len);
                    scan_mode = M_IDLE;
                end
                return;
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    scan_mode = M_LINE;
                    return;
                end
                if (c == "*")
                begin
                    scan_mode = M_BLOCK;
                    return;
                end
                push_token(K_SLASH, E_NONE, tok_start, 16'd1);
            end
            M_OP2:
            begin
                if (c == "=")
                begin
                    push_token(op_single(held_op) + 6'd1, E_NONE, tok_start, 16'd2);
                    scan_mode = M_IDLE;
                    return;
                end
                push_token(op_single(held_op), E_NONE, tok_start, 16'd1);
            end
            M_LINE:
            begin
                if (c == 8'h0A)
                begin
                    count_line();
                    scan_mode = M_IDLE;
                end
                return;
            end
            M_BLOCK:
            begin
                if (c == 8'h0A)
                    count_line();
                else if (c == "*")
                    scan_mode = M_BSTAR;
                return;
            end
            M_BSTAR:
            begin
                if (c == "/")
                    scan_mode = M_IDLE;
                else if (c != "*")
                begin
                    if (c == 8'h0A)
                        count_line();
                    scan_mode = M_BLOCK;
                end
                return;
            end
            default: ;
        endcase
        scan_fresh(c);
    endfunction

    function automatic void close_source();
        case (scan_mode)
            M_IDENT:  push_token(classify_word(), E_NONE, tok_start, lex_len);
            M_NUMBER: push_token(K_NUMBER, E_NONE, tok_start, lex_len);
            M_STRING: push_token(K_ERROR, E_UNTERM, tok_start, 16'd0);
            M_SLASH:  push_token(K_SLASH, E_NONE, tok_start, 16'd1);
            M_OP2:    push_token(op_single(held_op), E_NONE, tok_start, 16'd1);
            default: ;
        endcase
        push_token(K_EOF, E_NONE, byte_pos, 16'd0);
        clear_scanner();
    endfunction

    // Work out the tokens one accepted transaction causes; returns the index of the first
    function automatic int predict_tokens(logic [7:0] c, logic eos);
        int first;
        first = token_q.size();
        if (eos)
        begin
            close_source();
            sources_closed++;
        end
        else
        begin
            scan_next(c);
            if (byte_pos != OFFSET_TOP)
                byte_pos++;
        end
        if (token_q.size() > first)
            token_q[token_q.size() - 1].last = 1'b1;
        return first;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #40ms;
        $display("%0t timeout with %0d tokens outstanding", $time, token_q.size());
        $display("tb: failure");
        $finish;
    end

    // Drive one transaction on src and advance the prediction once it is taken
    task automatic send_byte(input logic [7:0] c, input logic eos, output int first);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            src.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src.valid         <= 1'b1;
        src.ch            <= c;
        src.end_of_source <= eos;
        @(posedge clk);
        while (!src.ready)
            @(posedge clk);
        bytes_sent++;
        first = predict_tokens(c, eos);
    endtask

    task automatic send_text(input string s);
        int first;
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0, first);
    endtask

    function automatic string random_word(int lo, int hi);
        string s;
        int    n;
        n = $urandom_range(lo, hi);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0:       s = {s, string'(8'($urandom_range("a", "z")))};
                1:       s = {s, string'(8'($urandom_range("A", "Z")))};
                2:       s = {s, (i == 0) ? "_" : string'(8'($urandom_range("0", "9")))};
                default: s = {s, "_"};
            endcase
        end
        return s;
    endfunction

    // One random phrase of source text, mostly well formed
    task automatic send_phrase();
        string s;
        string ops;
        int    first;
        int    n;
        ops = "(){};,.-+*/!=<>";
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                s = keyword_text[$urandom_range(0, 15)];
                // Chop or extend keywords now and then to hit near misses
                if ($urandom_range(0, 3) == 0)
                    s = s.substr(0, s.len() - 2);
                else if ($urandom_range(0, 3) == 0)
                    s = {s, random_word(1, 2)};
            end
            3, 4:    s = random_word(1, 11);
            5:
            begin
                n = $urandom_range(1, 6);
                s = "";
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range("0", "9")))};
            end
            6:
            begin
                n = $urandom_range(0, 6);
                s = "\"";
                for (int i = 0; i < n; i++)
                    s = {s, ($urandom_range(0, 5) == 0) ? "\n" :
                         string'(8'($urandom_range(8'h23, 8'h7E)))};
                s = {s, "\""};
            end
            7, 8, 9:
            begin
                s = string'(ops[$urandom_range(0, ops.len() - 1)]);
                if ($urandom_range(0, 2) == 0)
                    s = {s, "="};
            end
            10:      s = {"//", random_word(0, 5), "\n"};
            11:
            begin
                s = {"/*", random_word(0, 3), ($urandom_range(0, 1) ? "\n" : "**"),
                     ($urandom_range(0, 1) ? "*x" : ""), "*/"};
            end
            12, 13:
            begin
                case ($urandom_range(0, 3))
                    0:       s = " ";
                    1:       s = "\t";
                    2:       s = "\r";
                    default: s = "\n";
                endcase
            end
            14, 15:
            begin
                // Noise: any byte at all
                send_byte(8'($urandom_range(0, 255)), 1'b0, first);
                return;
            end
            16:      s = {"\"", random_word(0, 3)};         // may be left open
            17:      s = {"/*", random_word(0, 3)};         // may be left open
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1, first);
                    return;
                end
                s = " ";
            end
        endcase
        send_text(s);
    endtask

    // Token sink with random back-pressure and the field checks
    initial
    begin
        token_exp_t want;
        int         gap;
        tok.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                tok.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tok.ready <= 1'b1;
            @(posedge clk);
            while (!tok.valid)
                @(posedge clk);
            tokens_seen++;
            if (token_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t unexpected token: expected none, got kind %0d at %0d",
                         $time, tok.kind, tok.start_offset);
            end
            else
            begin
                want = token_q.pop_front();
                if (tok.kind !== want.kind || tok.err_code !== want.err_code ||
                    tok.start_offset !== want.start_offset ||
                    tok.token_length !== want.token_length ||
                    tok.line_number !== want.line_number || tok.last !== want.last)
                begin
                    fail_cnt++;
                    $display("%0t token mismatch: expected k%0d e%0d s%0d l%0d n%0d last%0b",
                             $time, want.kind, want.err_code, want.start_offset,
                             want.token_length, want.line_number, want.last);
                    $display("%0t                 actual   k%0d e%0d s%0d l%0d n%0d last%0b",
                             $time, tok.kind, tok.err_code, tok.start_offset,
                             tok.token_length, tok.line_number, tok.last);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        int first;
        int waited;
        fail_cnt          = 0;
        bytes_sent        = 0;
        sources_closed    = 0;
        tokens_seen       = 0;
        calm              = 1'b0;
        stim_done         = 1'b0;
        src.valid         = 1'b0;
        src.ch            = '0;
        src.end_of_source = 1'b0;
        clear_scanner();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: hold the typed first token against the prediction
        foreach (lex_rows[r])
        begin
            send_byte(lex_rows[r].ch, lex_rows[r].eos, first);
            if (lex_rows[r].typed)
            begin
                if (token_q.size() <= first || token_q[first].kind !== lex_rows[r].kind ||
                    token_q[first].err_code !== lex_rows[r].err_code)
                begin
                    fail_cnt++;
                    $display("%0t directed row %0d: expected k%0d e%0d, predicted otherwise",
                             $time, r, lex_rows[r].kind, lex_rows[r].err_code);
                end
            end
        end

        // Random phrases, with stretches of no idling
        while (bytes_sent < 1000)
        begin
            if ($urandom_range(0, 15) == 0)
                calm = ~calm;
            send_phrase();
        end
        calm = 1'b0;
        send_byte(8'h00, 1'b1, first);

        // Drop valid on the accepting edge and drain
        src.valid <= 1'b0;
        stim_done = 1'b1;
        waited = 0;
        while (token_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        if (token_q.size() != 0)
        begin
            fail_cnt++;
            $display("%0t %0d expected tokens never arrived", $time, token_q.size());
        end
        $display("run covered %0d bytes over %0d sources, %0d tokens checked",
                 bytes_sent, sources_closed, tokens_seen);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/stok_pkg.sv
rtl/stok_if.sv
rtl/stok_front.sv
rtl/stok_fifo.sv
rtl/stok_back.sv
rtl/source_tokenizer_top.sv
bench/testbench.sv
